// ===== sv/ibd_pkg.sv =====
package ibd_pkg;

  localparam int unsigned CodeW  = 4;
  localparam int unsigned ValueW = 24;
  localparam int unsigned ByteW  = 8;

  localparam logic [CodeW-1:0] CodeFlags      = 4'd0;
  localparam logic [CodeW-1:0] CodeSpeed      = 4'd1;
  localparam logic [CodeW-1:0] CodeAvgSpeed   = 4'd2;
  localparam logic [CodeW-1:0] CodeCadence    = 4'd3;
  localparam logic [CodeW-1:0] CodeAvgCadence = 4'd4;
  localparam logic [CodeW-1:0] CodeDistance   = 4'd5;
  localparam logic [CodeW-1:0] CodeResistance = 4'd6;
  localparam logic [CodeW-1:0] CodePower      = 4'd7;
  localparam logic [CodeW-1:0] CodeAvgPower   = 4'd8;
  localparam logic [CodeW-1:0] CodeEnergy     = 4'd9;
  localparam logic [CodeW-1:0] CodeEnergyHour = 4'd10;
  localparam logic [CodeW-1:0] CodeEnergyMin  = 4'd11;
  localparam logic [CodeW-1:0] CodeHeartRate  = 4'd12;
  localparam logic [CodeW-1:0] CodeMet        = 4'd13;
  localparam logic [CodeW-1:0] CodeElapsed    = 4'd14;
  localparam logic [CodeW-1:0] CodeRemaining  = 4'd15;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             record_start;
  } rec_item_t;

  typedef struct packed {
    logic [CodeW-1:0]  field_code;
    logic [ValueW-1:0] field_value;
    logic              last_field;
  } fld_item_t;

  typedef struct packed {
    logic      valid;
    fld_item_t item;
  } core_res_t;

endpackage

// ===== sv/indoor_bike_data_field_parser.sv =====
// channel  | valid      | ready      | payload
// ---------+------------+------------+---------------------------------------
// bytes in | rec_valid  | rec_ready  | rec_item  (data_byte, record_start)
// fields   | fld_valid  | fld_ready  | fld_item  (field_code, field_value,
//          |            |            |            last_field)
// config   | cfg_wr_en  | -          | cfg_wr_data (speed_on_bit0_clear)
//
// one byte per cycle sustained while fld_ready does not stall; a byte is held
// in the input register, and its field, if it completes one, is registered
// from there into the output register
// rst is synchronous; the parser starts idle until a record_start byte
// a stall on fld_ready holds the output register and the input register,
// and rec_ready drops only when both are full
module indoor_bike_data_field_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_valid,
  output logic               rec_ready,
  input  ibd_pkg::rec_item_t rec_item,
  output logic               fld_valid,
  input  logic               fld_ready,
  output ibd_pkg::fld_item_t fld_item,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);
  import ibd_pkg::*;

  logic      speed_on_bit0_clear;
  logic      in_full;
  rec_item_t in_item;
  logic      advance;
  core_res_t res;

  assign advance   = !fld_valid || fld_ready;
  assign rec_ready = !in_full || advance;

  ibd_parse_core u_core (
    .clk                 (clk),
    .rst                 (rst),
    .step                (in_full && advance),
    .item                (in_item),
    .speed_on_bit0_clear (speed_on_bit0_clear),
    .res                 (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_on_bit0_clear <= 1'b1;
    end else if (cfg_wr_en) begin
      speed_on_bit0_clear <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rec_ready) begin
      in_full <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && rec_ready) begin
      in_item <= rec_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fld_valid <= 1'b0;
    end else if (advance) begin
      fld_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      fld_item <= res.item;
    end
  end

endmodule

// ===== sv/ibd_parse_core.sv =====
module ibd_parse_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  ibd_pkg::rec_item_t item,
  input  logic               speed_on_bit0_clear,
  output ibd_pkg::core_res_t res
);
  import ibd_pkg::*;

  logic [15:0]       flag_word, flag_word_next;
  logic [CodeW-1:0]  current_field, current_field_next;
  logic [1:0]        bytes_collected, bytes_collected_next;
  logic [ValueW-1:0] value_accumulator, value_accumulator_next;
  logic              record_done, record_done_next;

  function automatic logic [1:0] field_len(input logic [CodeW-1:0] c);
    unique case (c) inside
      CodeDistance:                          field_len = 2'd3;
      CodeEnergyMin, CodeHeartRate, CodeMet: field_len = 2'd1;
      default:                               field_len = 2'd2;
    endcase
  endfunction

  function automatic logic [3:0] field_bit(input logic [CodeW-1:0] c);
    unique case (c) inside
      CodeFlags, CodeSpeed:                          field_bit = 4'd0;
      CodeEnergy, CodeEnergyHour, CodeEnergyMin:     field_bit = 4'd8;
      CodeHeartRate, CodeMet, CodeElapsed, CodeRemaining:
                                                     field_bit = 4'(c - 4'd3);
      default:                                       field_bit = 4'(c - 4'd1);
    endcase
  endfunction

  logic [15:0]       flags_eff;
  logic [15:0]       present;
  logic [CodeW-1:0]  code_base;
  logic [1:0]        bc_base, bc_inc;
  logic [ValueW-1:0] acc_base, acc_new;
  logic              active, complete;
  logic [CodeW-1:0]  nxt;

  always_comb begin
    code_base = item.record_start ? CodeFlags : current_field;
    bc_base   = item.record_start ? 2'd0 : bytes_collected;
    acc_base  = item.record_start ? '0 : value_accumulator;
    active    = item.record_start || !record_done;

    acc_new = acc_base | (ValueW'(item.data_byte) << {bc_base, 3'b000});
    bc_inc  = bc_base + 2'd1;
    complete = active && (bc_inc >= field_len(code_base));

    flags_eff = (code_base == CodeFlags) ? acc_new[15:0]
              : (item.record_start ? 16'd0 : flag_word);

    for (int c = 0; c < 16; c++) begin
      present[c] = flags_eff[field_bit(CodeW'(c))];
    end
    present[CodeSpeed] = speed_on_bit0_clear ? !flags_eff[0] : flags_eff[0];

    nxt = CodeFlags;
    for (int c = 15; c >= 1; c--) begin
      if (present[c] && (CodeW'(c) > code_base)) nxt = CodeW'(c);
    end

    flag_word_next         = item.record_start ? 16'd0 : flag_word;
    current_field_next     = code_base;
    bytes_collected_next   = bc_base;
    value_accumulator_next = acc_base;
    record_done_next       = record_done && !item.record_start;
    if (active) begin
      if (complete) begin
        if (code_base == CodeFlags) flag_word_next = acc_new[15:0];
        current_field_next     = nxt;
        bytes_collected_next   = 2'd0;
        value_accumulator_next = '0;
        record_done_next       = (nxt == CodeFlags);
      end else begin
        bytes_collected_next   = bc_inc;
        value_accumulator_next = acc_new;
      end
    end

    res.valid            = step && complete;
    res.item.field_code  = code_base;
    res.item.field_value = acc_new;
    res.item.last_field  = (nxt == CodeFlags);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_word         <= '0;
      current_field     <= CodeFlags;
      bytes_collected   <= '0;
      value_accumulator <= '0;
      record_done       <= 1'b1;
    end else if (step) begin
      flag_word         <= flag_word_next;
      current_field     <= current_field_next;
      bytes_collected   <= bytes_collected_next;
      value_accumulator <= value_accumulator_next;
      record_done       <= record_done_next;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ibd_pkg::*;

  class ibd_field_checker;
    bit               speed_on_clear;
    logic [15:0]      flags;
    logic [CodeW-1:0] field;
    int               nbytes;
    logic [ValueW-1:0] acc;
    bit               idle;
    fld_item_t        fields_due[$];
    int               errors;

    function new();
      speed_on_clear = 1'b1;
      flags          = '0;
      field          = CodeFlags;
      nbytes         = 0;
      acc            = '0;
      idle           = 1'b1;
      errors         = 0;
    endfunction

    function int pending();
      return fields_due.size();
    endfunction

    function int field_len(logic [CodeW-1:0] code);
      case (code) inside
        CodeDistance: return 3;
        CodeEnergyMin, CodeHeartRate, CodeMet: return 1;
        default: return 2;
      endcase
    endfunction

    function int field_bit(logic [CodeW-1:0] code);
      if (code <= CodeSpeed) return 0;
      if (code <= CodeAvgPower) return int'(code) - 1;
      if (code <= CodeEnergyMin) return 8;
      return int'(code) - 3;
    endfunction

    function bit present(logic [15:0] fw, logic [CodeW-1:0] code);
      bit b;
      b = fw[field_bit(code)];
      if (code == CodeSpeed) return speed_on_clear ? !b : b;
      return b;
    endfunction

    function logic [CodeW-1:0] next_field(logic [15:0] fw, logic [CodeW-1:0] code);
      int c;
      for (c = int'(code) + 1; c < 16; c++) begin
        if (present(fw, 4'(c))) return 4'(c);
      end
      return CodeFlags;
    endfunction

    function int record_len(logic [15:0] fw);
      int n;
      n = 2;
      for (int c = 1; c < 16; c++) begin
        if (present(fw, 4'(c))) n += field_len(4'(c));
      end
      return n;
    endfunction

    function void take_byte(rec_item_t it);
      logic [CodeW-1:0] nxt;
      fld_item_t        want;
      if (it.record_start) begin
        flags  = '0;
        field  = CodeFlags;
        nbytes = 0;
        acc    = '0;
        idle   = 1'b0;
      end else if (idle) begin
        return;
      end
      acc = acc | (ValueW'(it.data_byte) << (8 * nbytes));
      nbytes++;
      if (nbytes < field_len(field)) return;
      if (field == CodeFlags) flags = acc[15:0];
      nxt = next_field(flags, field);
      want.field_code  = field;
      want.field_value = acc;
      want.last_field  = (nxt == CodeFlags);
      fields_due.push_back(want);
      if (nxt == CodeFlags) idle = 1'b1;
      field  = nxt;
      nbytes = 0;
      acc    = '0;
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR %0t: %s", $realtime, msg);
    endtask

    task check_field(fld_item_t got);
      fld_item_t want;
      if (fields_due.size() == 0) begin
        report($sformatf("field with no request behind it: code %0d value %06h",
                         got.field_code, got.field_value));
        return;
      end
      want = fields_due.pop_front();
      if (got.field_code !== want.field_code)
        report($sformatf("field_code %0d, want %0d", got.field_code, want.field_code));
      if (got.field_value !== want.field_value)
        report($sformatf("field_value %06h, want %06h (code %0d)",
                         got.field_value, want.field_value, want.field_code));
      if (got.last_field !== want.last_field)
        report($sformatf("last_field %0b, want %0b (code %0d)",
                         got.last_field, want.last_field, want.field_code));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      rec_valid = 1'b0;
  logic      rec_ready;
  rec_item_t rec_item = '0;
  logic      fld_valid;
  logic      fld_ready = 1'b0;
  fld_item_t fld_item;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;

  ibd_field_checker sb = new();
  bit               send_burst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  indoor_bike_data_field_parser dut (
    .clk         (clk),
    .rst         (rst),
    .rec_valid   (rec_valid),
    .rec_ready   (rec_ready),
    .rec_item    (rec_item),
    .fld_valid   (fld_valid),
    .fld_ready   (fld_ready),
    .fld_item    (fld_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  function automatic rec_item_t mk_byte(logic [7:0] v, logic s);
    rec_item_t r;
    r.data_byte    = v;
    r.record_start = s;
    return r;
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] draw_flags();
    logic [15:0] fw;
    case ($urandom_range(0, 3))
      0: fw = 16'($urandom);
      1: for (int i = 0; i < 16; i++) fw[i] = ($urandom_range(0, 3) == 0);
      2: fw = 16'h0001 << $urandom_range(0, 15);
      default: for (int i = 0; i < 16; i++) fw[i] = ($urandom_range(0, 3) != 0);
    endcase
    return fw;
  endfunction

  task automatic send_byte(rec_item_t it);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      rec_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rec_valid <= 1'b1;
    rec_item  <= it;
    do @(posedge clk); while (rec_ready !== 1'b1);
    sb.take_byte(it);
  endtask

  task automatic settle();
    @(negedge clk);
    rec_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.speed_on_clear = v;
  endtask

  task automatic run_phase(int target);
    int          sent;
    int          kind;
    int          len;
    int          cut;
    logic [15:0] fw;
    sent = 0;
    while (sent < target) begin
      send_burst = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // stray bytes, normally ignored between records
        repeat ($urandom_range(1, 3)) send_byte(mk_byte(rand_byte(), 1'b0));
      end else begin
        fw  = draw_flags();
        len = sb.record_len(fw);
        cut = (kind == 1) ? $urandom_range(1, len - 1) : len;
        send_byte(mk_byte(fw[7:0], 1'b1));
        if (cut > 1) send_byte(mk_byte(fw[15:8], 1'b0));
        for (int i = 2; i < cut; i++) send_byte(mk_byte(rand_byte(), 1'b0));
        sent += cut;
        if (kind == 9) repeat ($urandom_range(1, 3)) send_byte(mk_byte(rand_byte(), 1'b0));
      end
    end
  endtask

  initial begin : stall_side
    int stall;
    int nres;
    bit rburst;
    nres   = 0;
    rburst = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (nres % 40 == 0) rburst = ($urandom_range(0, 2) == 0);
      stall = rburst ? 0 : $urandom_range(0, 15);
      // long hold-off so the parser backs up into its input
      if (nres == 200 || nres == 600) stall = 300;
      if (stall > 0) begin
        fld_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      fld_ready <= 1'b1;
      do @(posedge clk); while (fld_valid !== 1'b1);
      sb.check_field(fld_item);
      nres++;
    end
  end

  initial begin
    logic [8:0] opening [24];
    // bit 8 is record_start
    opening = '{9'h0A5, 9'h101, 9'h000, 9'h0FF,
                9'h100, 9'h180, 9'h000, 9'h0FF, 9'h0FF, 9'h000, 9'h080,
                9'h110, 9'h0FE, 9'h034, 9'h012, 9'h0FF, 9'h0FF, 9'h0FF,
                9'h000, 9'h0FF, 9'h001, 9'h000, 9'h0FE, 9'h0FF};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_burst = 1'b0;
    foreach (opening[i]) send_byte(mk_byte(opening[i][7:0], opening[i][8]));
    settle();
    for (int p = 0; p < 4; p++) begin
      write_mode(p % 2 == 1);
      run_phase(470);
      settle();
    end
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
